>>> rtl/tccw_pkg.sv
// tccw_pkg: types and constants shared by the text console cell writer
// no dependencies; imported by every module of the block
`default_nettype none

package tccw_pkg;

  localparam int ADDR_W  = 11;
  localparam int CFG_W   = 32;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int IVAL_W  = 32;

  localparam logic [CHAR_W-1:0] CH_NUL        = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BS         = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB        = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL         = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR         = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
  localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;

  localparam logic [ATTR_W-1:0] COLOR_RESET = 8'd15;
  localparam logic [IVAL_W-1:0] BLINK_RESET = 32'd250;

  typedef enum logic {
    REG_COLOR = 1'b0,
    REG_BLINK = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_CHAR  = 2'd0,
    OP_LEFT  = 2'd1,
    OP_RIGHT = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef struct packed {
    logic [ATTR_W-1:0] attr;
    logic [CHAR_W-1:0] code;
  } cell_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_ADV,
    CUR_RET,
    CUR_NL,
    CUR_CR
  } cur_op_t;

  typedef struct packed {
    logic tick_inc;
    logic last_clear;
    logic last_take;
  } blink_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAB,
    ST_BS2,
    ST_BLINK,
    ST_SHOW,
    ST_MOVE_RD,
    ST_MOVE_SET
  } state_t;

endpackage

`default_nettype wire

>>> rtl/text_console_cell_writer_unit.sv
// text_console_cell_writer_unit: top level, command sequencer and config regs
// depends on tccw_pkg, tccw_cell_store, tccw_cursor, tccw_blink
//
// usage:
//   a command is taken at a rising edge with start high and busy low; op and
//   char_code are sampled there. config regs are written through wr_en,
//   wr_index and wr_data while the unit is idle.
//   each cell write appears for one cycle with strobe high, in the cycle after
//   the sequencer step that makes it; last marks the final write of a command.
//   the receiver cannot stall, so there is no back pressure on the results.
// steps per command (set by the one-write one-read cell memory port):
//   printable, newline, return, zero byte: the idle step alone
//   tab: then one space per cycle up to the next tab stop or the line end
//   backspace: two cell writes, then a blink check if due; tick: blink check
//   cursor move: write back, read of the new cell, blink check
// a blink that shows the cursor reads the cell under it in a further step.
// reset: cursor, blink timing and saved cell go to zero, config to defaults;
//   the cell memory is then swept to zero, all ROWS*COLUMNS cells (2000 by
//   default), while busy stays high.
`default_nettype none

module text_console_cell_writer_unit #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TICK_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    op,
  input  wire logic [tccw_pkg::CHAR_W-1:0]   char_code,
  input  wire logic                          wr_en,
  input  wire logic                          wr_index,
  input  wire logic [tccw_pkg::CFG_W-1:0]    wr_data,
  output logic                               strobe,
  output logic [tccw_pkg::ADDR_W-1:0]        cell_address,
  output logic [tccw_pkg::CHAR_W-1:0]        cell_char,
  output logic [tccw_pkg::ATTR_W-1:0]        cell_attr,
  output logic                               last
);
  import tccw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CW    = $clog2(COLUMNS);
  localparam int AW    = $clog2(CELLS);

  state_t             state, state_next;
  logic [ATTR_W-1:0]  color_attribute;
  logic [IVAL_W-1:0]  blink_period;
  cell_t              saved_cell;
  logic               cursor_shown;

  logic               clearing;
  logic               accept;
  logic [CW-1:0]      col;
  logic [AW-1:0]      addr;
  logic               at_line_end;
  logic               tab_end;
  cur_op_t            cur_cmd;
  blink_cmd_t         bcmd;
  logic               pass, pass_zero;
  cell_t              rd_cell;

  logic               mw_en;
  cell_t              mw_cell;
  logic               mw_last;
  logic               saved_take;
  logic               shown_clear;
  logic               shown_toggle;

  assign busy    = clearing || (state != ST_IDLE);
  assign accept  = start && !busy;
  assign tab_end = at_line_end || (col[1:0] == 2'b11);

  tccw_cell_store #(
    .CELLS (CELLS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .we       (mw_en),
    .waddr    (addr),
    .wdata    (mw_cell),
    .raddr    (addr),
    .rdata    (rd_cell),
    .clearing (clearing)
  );

  tccw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cur_cmd),
    .col         (col),
    .addr        (addr),
    .at_line_end (at_line_end)
  );

  tccw_blink #(
    .TICK_BITS (TICK_BITS)
  ) u_blink (
    .clk       (clk),
    .rst       (rst),
    .cmd       (bcmd),
    .interval  (blink_period),
    .pass      (pass),
    .pass_zero (pass_zero)
  );

  always_comb begin
    state_next   = state;
    cur_cmd      = CUR_HOLD;
    bcmd         = '0;
    mw_en        = 1'b0;
    mw_cell      = '0;
    mw_last      = 1'b0;
    saved_take   = 1'b0;
    shown_clear  = 1'b0;
    shown_toggle = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_t'(op))
            OP_CHAR: begin
              unique case (char_code)
                CH_NUL: ;
                CH_BS: begin
                  mw_en      = 1'b1;
                  cur_cmd    = CUR_RET;
                  state_next = ST_BS2;
                end
                CH_TAB: state_next = ST_TAB;
                CH_NL: begin
                  mw_en   = 1'b1;
                  mw_last = 1'b1;
                  cur_cmd = CUR_NL;
                end
                CH_CR: cur_cmd = CUR_CR;
                default: begin
                  mw_en   = 1'b1;
                  mw_cell = '{attr: color_attribute, code: char_code};
                  mw_last = 1'b1;
                  cur_cmd = CUR_ADV;
                end
              endcase
            end
            OP_LEFT, OP_RIGHT: begin
              mw_en      = 1'b1;
              mw_cell    = saved_cell;
              mw_last    = !pass_zero;
              cur_cmd    = (op_t'(op) == OP_LEFT) ? CUR_RET : CUR_ADV;
              state_next = ST_MOVE_RD;
            end
            OP_TICK: begin
              bcmd.tick_inc = 1'b1;
              state_next    = ST_BLINK;
            end
            default: ;
          endcase
        end
      end
      ST_TAB: begin
        mw_en   = 1'b1;
        mw_cell = '{attr: color_attribute, code: CH_SPACE};
        mw_last = tab_end;
        cur_cmd = CUR_ADV;
        if (tab_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_BS2: begin
        mw_en           = 1'b1;
        mw_last         = !pass_zero;
        bcmd.last_clear = 1'b1;
        state_next      = pass_zero ? ST_BLINK : ST_IDLE;
      end
      ST_BLINK: begin
        state_next = ST_IDLE;
        if (pass) begin
          bcmd.last_take = 1'b1;
          shown_toggle   = 1'b1;
          if (!cursor_shown) begin
            state_next = ST_SHOW;
          end else begin
            mw_en   = 1'b1;
            mw_cell = saved_cell;
            mw_last = 1'b1;
          end
        end
      end
      ST_SHOW: begin
        saved_take = 1'b1;
        mw_en      = 1'b1;
        mw_cell    = '{attr: color_attribute, code: CH_UNDERSCORE};
        mw_last    = 1'b1;
        state_next = ST_IDLE;
      end
      ST_MOVE_RD: begin
        bcmd.last_clear = 1'b1;
        shown_clear     = 1'b1;
        state_next      = ST_MOVE_SET;
      end
      ST_MOVE_SET: begin
        saved_take = 1'b1;
        state_next = ST_BLINK;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cursor_shown <= 1'b0;
      saved_cell   <= '0;
    end else begin
      state <= state_next;
      if (shown_clear) begin
        cursor_shown <= 1'b0;
      end else if (shown_toggle) begin
        cursor_shown <= !cursor_shown;
      end
      if (saved_take) begin
        saved_cell <= rd_cell;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      color_attribute <= COLOR_RESET;
      blink_period    <= BLINK_RESET;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_COLOR: color_attribute <= wr_data[ATTR_W-1:0];
        REG_BLINK: blink_period    <= wr_data[IVAL_W-1:0];
        default: ;
      endcase
    end
  end

  // result transaction register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= mw_en;
    end
  end

  always_ff @(posedge clk) begin
    if (mw_en) begin
      cell_address <= ADDR_W'(addr);
      cell_char    <= mw_cell.code;
      cell_attr    <= mw_cell.attr;
      last         <= mw_last;
    end
  end

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !strobe && (state == ST_IDLE))
    else $error("result or command activity during the clearing sweep");

  a_more_writes_keep_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("non-final cell write while the unit is idle");

  a_shown_changes_in_blink: assert property (@(posedge clk) disable iff (rst)
    (cursor_shown != $past(cursor_shown)) |->
      ($past(state) == ST_BLINK) || ($past(state) == ST_MOVE_RD))
    else $error("cursor shown flag changed outside a blink check or move");

endmodule

`default_nettype wire

>>> rtl/tccw_cell_store.sv
// tccw_cell_store: shadow cell memory, one write and one registered read port
// clears itself after reset; uses tccw_pkg
`default_nettype none

module tccw_cell_store #(
  parameter int CELLS = 2000
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       we,
  input  wire logic [$clog2(CELLS)-1:0]   waddr,
  input  wire tccw_pkg::cell_t            wdata,
  input  wire logic [$clog2(CELLS)-1:0]   raddr,
  output tccw_pkg::cell_t                 rdata,
  output logic                            clearing
);
  import tccw_pkg::*;

  localparam int AW = $clog2(CELLS);

  cell_t          mem [CELLS];
  logic [AW-1:0]  clr_addr;

  // clearing sweep, one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(CELLS - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/tccw_cursor.sv
// tccw_cursor: cursor column and row with advance, retreat, newline, return
// produces the cell address of the cursor; uses tccw_pkg
`default_nettype none

module tccw_cursor #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire tccw_pkg::cur_op_t                   cmd,
  output logic [$clog2(COLUMNS)-1:0]               col,
  output logic [$clog2(ROWS*COLUMNS)-1:0]          addr,
  output logic                                     at_line_end
);
  import tccw_pkg::*;

  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);
  localparam int AW = $clog2(ROWS * COLUMNS);

  logic [RW-1:0] row, row_next, row_down;
  logic [CW-1:0] col_next;
  logic          at_last_row;

  assign at_line_end = (col == CW'(COLUMNS - 1));
  assign at_last_row = (row == RW'(ROWS - 1));
  assign row_down    = at_last_row ? row : row + RW'(1);
  assign addr        = AW'(row) * AW'(COLUMNS) + AW'(col);

  always_comb begin
    col_next = col;
    row_next = row;
    unique case (cmd)
      CUR_HOLD: ;
      CUR_ADV: begin
        if (at_line_end) begin
          col_next = '0;
          row_next = row_down;
        end else begin
          col_next = col + CW'(1);
        end
      end
      CUR_RET: begin
        if (col != '0) begin
          col_next = col - CW'(1);
        end else if (row != '0) begin
          col_next = CW'(COLUMNS - 1);
          row_next = row - RW'(1);
        end
      end
      CUR_NL: begin
        col_next = '0;
        row_next = row_down;
      end
      CUR_CR: col_next = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tccw_blink.sv
// tccw_blink: tick counter and last blink time with the blink interval compare
// uses tccw_pkg
`default_nettype none

module tccw_blink #(
  parameter int TICK_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire tccw_pkg::blink_cmd_t          cmd,
  input  wire logic [tccw_pkg::IVAL_W-1:0]   interval,
  output logic                               pass,
  output logic                               pass_zero
);
  import tccw_pkg::*;

  localparam int CMP_W = (TICK_BITS > IVAL_W) ? TICK_BITS : IVAL_W;

  logic [TICK_BITS-1:0] tick_count;
  logic [TICK_BITS-1:0] last_blink;
  logic [TICK_BITS-1:0] age;

  assign age       = tick_count - last_blink;
  assign pass      = CMP_W'(age) >= CMP_W'(interval);
  // age as if the last blink time were zero
  assign pass_zero = CMP_W'(tick_count) >= CMP_W'(interval);

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      last_blink <= '0;
    end else begin
      if (cmd.tick_inc) begin
        tick_count <= tick_count + TICK_BITS'(1);
      end
      if (cmd.last_clear) begin
        last_blink <= '0;
      end else if (cmd.last_take) begin
        last_blink <= tick_count;
      end
    end
  end

endmodule

`default_nettype wire
